// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the parity duplication EDAC checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define BPDE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checked at every rising edge, reset included.
`define BPDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ----- sv/bpde_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpde_pkg
// Types, codes and parity helpers shared by the EDAC and its checker.
// ----------------------------------------------------------------------------
package bpde_pkg;

	localparam int unsigned NUM_BYTES = 4;

	localparam logic KIND_ENCODE = 1'b0;
	localparam logic KIND_CHECK  = 1'b1;

	localparam logic [1:0] STATUS_CLEAN         = 2'd0;
	localparam logic [1:0] STATUS_CORRECTED     = 2'd1;
	localparam logic [1:0] STATUS_UNCORRECTABLE = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [31:0] data_word;
		logic [31:0] copy_word;
		logic [7:0]  check_byte;
	} bpde_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data_out;
		logic [31:0] copy_out;
		logic [7:0]  check_out;
	} bpde_rsp_t;

	// Even parity of each byte, byte i in bit i.
	function automatic logic [3:0] byte_parities(input logic [31:0] w);
		logic [3:0] p;
		for (int i = 0; i < NUM_BYTES; i++) begin
			p[i] = ^w[8*i +: 8];
		end
		return p;
	endfunction

	// Check byte: the same four parities for the word and for its copy.
	function automatic logic [7:0] make_check(input logic [31:0] w);
		logic [3:0] p;
		p = byte_parities(w);
		return {p, p};
	endfunction

endpackage

// ----- sv/byte_parity_duplication_edac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_parity_duplication_edac
// Encode and check/correct of a 32-bit word kept with a full duplicate and a
// byte-parity check byte.
// ----------------------------------------------------------------------------
// The block takes one request per clock when not stalled and returns exactly
// one response for each, in order, through the input register and then the
// result register. The whole decode sits in one stage of short logic (byte
// parity trees, byte compares and a byte-wise select), so a steady rate of
// one word per clock is held while the response side is not stalling. An
// encode request returns the word, a copy equal to it and a fresh check byte
// with status clean. A check request either passes the stored word through
// as clean, repairs every byte whose own parity is wrong from the duplicate
// and re-encodes the result (status corrected), or flags the word as
// uncorrectable and passes the stored fields through unchanged.
// ----------------------------------------------------------------------------
module byte_parity_duplication_edac (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  bpde_pkg::bpde_req_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output bpde_pkg::bpde_rsp_t  rsp
);

	// Pipeline control. The result register moves whenever it is empty or
	// its response is taken; the input register moves whenever it is empty
	// or the result register moves. A new request is therefore taken while
	// a finished response still waits, as long as one stage is free.
	logic                valid_s1;
	logic                valid_s2;
	bpde_pkg::bpde_req_t req_s1;
	bpde_pkg::bpde_rsp_t rsp_s2;
	logic                adv_s2;
	logic                adv_s1;

	assign adv_s2    = !valid_s2 || !rsp_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers load only on a transfer into their stage.
	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			req_s1 <= req;
		end
	end

	// Decode of the registered request.
	logic [3:0]          data_err;
	logic [3:0]          copy_err;
	logic [3:0]          differs;
	logic                uncorrectable;
	logic [31:0]         repaired;
	bpde_pkg::bpde_rsp_t result;

	always_comb begin
		data_err = bpde_pkg::byte_parities(req_s1.data_word) ^ req_s1.check_byte[3:0];
		copy_err = bpde_pkg::byte_parities(req_s1.copy_word) ^ req_s1.check_byte[7:4];
		for (int i = 0; i < bpde_pkg::NUM_BYTES; i++) begin
			differs[i]       = req_s1.data_word[8*i +: 8] != req_s1.copy_word[8*i +: 8];
			// A byte with bad data parity is taken from the duplicate.
			repaired[8*i +: 8] = data_err[i] ? req_s1.copy_word[8*i +: 8]
			                                 : req_s1.data_word[8*i +: 8];
		end
		// Both copies of a byte bad, or a difference that neither parity
		// explains, cannot be resolved.
		uncorrectable = (|(data_err & copy_err)) || (|(differs & ~(data_err | copy_err)));

		result.status    = bpde_pkg::STATUS_CLEAN;
		result.data_out  = req_s1.data_word;
		result.copy_out  = req_s1.copy_word;
		result.check_out = req_s1.check_byte;
		unique case (req_s1.kind)
			bpde_pkg::KIND_ENCODE: begin
				result.copy_out  = req_s1.data_word;
				result.check_out = bpde_pkg::make_check(req_s1.data_word);
			end
			bpde_pkg::KIND_CHECK: begin
				priority if (uncorrectable) begin
					result.status = bpde_pkg::STATUS_UNCORRECTABLE;
				end else if (|(data_err | copy_err)) begin
					result.status    = bpde_pkg::STATUS_CORRECTED;
					result.data_out  = repaired;
					result.copy_out  = repaired;
					result.check_out = bpde_pkg::make_check(repaired);
				end else begin
					result.status = bpde_pkg::STATUS_CLEAN;
				end
			end
			default: begin
				result.status = bpde_pkg::STATUS_CLEAN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

// ----- sv/bpde_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpde_checker
// Port-level checks of the parity duplication EDAC, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpde_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input bpde_pkg::bpde_rsp_t rsp
);

	// A stalled response stays and keeps its contents.
	`BPDE_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")

	// Requests are only held off when both stages are full and the output is blocked.
	`BPDE_ASSERT(a_stall_cause, clk, arst_n, req_stall |-> rsp_valid && rsp_stall, "request stalled without back-pressure")

	// A repaired word is written back as a consistent triple.
	`BPDE_ASSERT(a_corrected_triple, clk, arst_n, rsp_valid && rsp.status == bpde_pkg::STATUS_CORRECTED |-> rsp.copy_out == rsp.data_out && rsp.check_out == bpde_pkg::make_check(rsp.data_out), "corrected response not re-encoded")

	// Once reset has been seen at an edge, the next edge shows no response and no stall.
	`BPDE_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !rsp_valid && !req_stall, "activity during reset")

endmodule

bind byte_parity_duplication_edac bpde_checker u_bpde_checker (.*);
